@@ hw/rtl/tlb_pkg.sv @@
package tlb_pkg;

  // Sizing of the translator
  localparam int unsigned TlbEntries  = 16;
  localparam int unsigned PageCount   = 256;  // power of two
  localparam int unsigned OffsetWidth = 8;

  // Fixed field widths
  localparam int unsigned AddrWidth  = 16;
  localparam int unsigned FrameWidth = 8;

  // Derived widths
  localparam int unsigned VpnWidth     = AddrWidth - OffsetWidth;
  localparam int unsigned PageIdxWidth = $clog2(PageCount);
  localparam int unsigned TlbIdxWidth  = (TlbEntries > 1) ? $clog2(TlbEntries) : 1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic lookup;  // request taken: search TLB, read page table
    logic commit;  // resolve frame, update state, load result register
  } tlb_cmd_t;

endpackage

@@ hw/rtl/tlb_va_if.sv @@
interface tlb_va_if;
  logic                           valid;
  logic                           ready;
  logic [tlb_pkg::AddrWidth-1:0]  virtual_address;

  modport source (output valid, output virtual_address, input ready);
  modport sink   (input valid, input virtual_address, output ready);
endinterface

@@ hw/rtl/tlb_pa_if.sv @@
interface tlb_pa_if;
  logic                           valid;
  logic                           ready;
  logic [tlb_pkg::AddrWidth-1:0]  phys_addr;
  logic                           tlb_hit;
  logic                           page_fault;

  modport source (output valid, output phys_addr, output tlb_hit,
                  output page_fault, input ready);
  modport sink   (input valid, input phys_addr, input tlb_hit,
                  input page_fault, output ready);
endinterface

@@ hw/rtl/tlb_ctrl.sv @@
module tlb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output tlb_pkg::tlb_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   commit;

  // Result slot is free when empty or being drained this cycle
  assign commit = (state_q == S_COMMIT) && (!rsp_valid_q || rsp_ready_i);

  assign req_ready_o  = (state_q == S_IDLE);
  assign rsp_valid_o  = rsp_valid_q;
  assign cmd_o.lookup = req_valid_i && req_ready_o;
  assign cmd_o.commit = commit;

  // Next state
  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q;
    if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          state_d     = S_IDLE;
          rsp_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

@@ hw/rtl/tlb_datapath.sv @@
module tlb_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlb_pkg::tlb_cmd_t             cmd_i,
  input  logic [tlb_pkg::AddrWidth-1:0] virtual_address_i,
  output logic [tlb_pkg::AddrWidth-1:0] phys_addr_o,
  output logic                          tlb_hit_o,
  output logic                          page_fault_o
);

  localparam int unsigned TlbEntries   = tlb_pkg::TlbEntries;
  localparam int unsigned PageCount    = tlb_pkg::PageCount;
  localparam int unsigned OffsetWidth  = tlb_pkg::OffsetWidth;
  localparam int unsigned AddrWidth    = tlb_pkg::AddrWidth;
  localparam int unsigned FrameWidth   = tlb_pkg::FrameWidth;
  localparam int unsigned VpnWidth     = tlb_pkg::VpnWidth;
  localparam int unsigned PageIdxWidth = tlb_pkg::PageIdxWidth;
  localparam int unsigned TlbIdxWidth  = tlb_pkg::TlbIdxWidth;

  // TLB entries
  logic [TlbEntries-1:0]   tlb_valid_q;
  logic [PageIdxWidth-1:0] tlb_page_q  [TlbEntries];
  logic [FrameWidth-1:0]   tlb_frame_q [TlbEntries];
  logic [TlbIdxWidth-1:0]  tlb_ptr_q, tlb_ptr_d;

  // Page table: mapped flags in flops, frames in memory
  logic [PageCount-1:0]    mapped_q;
  logic [FrameWidth-1:0]   table_mem [PageCount];
  logic [FrameWidth-1:0]   table_rdata_q;
  logic [FrameWidth-1:0]   next_free_q;

  // Item held between lookup and commit
  logic [PageIdxWidth-1:0] page_q;
  logic [OffsetWidth-1:0]  offset_q;
  logic                    hit_q;
  logic [FrameWidth-1:0]   hit_frame_q;
  logic                    mapped_hit_q;

  // Result register
  logic [AddrWidth-1:0]    pa_q;
  logic                    res_hit_q;
  logic                    res_fault_q;

  // Address split, page number reduced to table size
  logic [VpnWidth+PageIdxWidth-1:0] vpn_ext;
  logic [PageIdxWidth-1:0]          page_in;
  logic [OffsetWidth-1:0]           offset_in;

  assign vpn_ext   = {{PageIdxWidth{1'b0}}, virtual_address_i[AddrWidth-1:OffsetWidth]};
  assign page_in   = vpn_ext[PageIdxWidth-1:0];
  assign offset_in = virtual_address_i[OffsetWidth-1:0];

  // Parallel TLB compare, lowest index wins
  logic                  match_any;
  logic [FrameWidth-1:0] match_frame;

  always_comb begin
    match_any   = 1'b0;
    match_frame = '0;
    for (int k = TlbEntries - 1; k >= 0; k--) begin
      if (tlb_valid_q[k] && (tlb_page_q[k] == page_in)) begin
        match_any   = 1'b1;
        match_frame = tlb_frame_q[k];
      end
    end
  end

  // Frame resolution at commit
  logic                  miss;
  logic                  fault;
  logic [FrameWidth-1:0] frame;
  logic [FrameWidth+OffsetWidth+AddrWidth-1:0] pa_ext;

  assign miss  = !hit_q;
  assign fault = miss && !mapped_hit_q;

  always_comb begin
    priority if (hit_q) begin
      frame = hit_frame_q;
    end else if (mapped_hit_q) begin
      frame = table_rdata_q;
    end else begin
      frame = next_free_q;
    end
  end

  assign pa_ext = {{AddrWidth{1'b0}}, frame, offset_q};

  // FIFO pointer wraps at the entry count
  always_comb begin
    if (tlb_ptr_q == TlbIdxWidth'(TlbEntries - 1)) begin
      tlb_ptr_d = '0;
    end else begin
      tlb_ptr_d = tlb_ptr_q + 1'b1;
    end
  end

  // Lookup capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q        <= 1'b0;
      mapped_hit_q <= 1'b0;
    end else if (cmd_i.lookup) begin
      hit_q        <= match_any;
      mapped_hit_q <= mapped_q[page_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      page_q      <= page_in;
      offset_q    <= offset_in;
      hit_frame_q <= match_frame;
    end
  end

  // Page table frame memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      table_rdata_q <= table_mem[page_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && fault) begin
      table_mem[page_q] <= next_free_q;
    end
  end

  // Control state updated on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q <= '0;
      tlb_ptr_q   <= '0;
      mapped_q    <= '0;
      next_free_q <= '0;
    end else if (cmd_i.commit) begin
      if (miss) begin
        tlb_valid_q[tlb_ptr_q] <= 1'b1;
        tlb_ptr_q              <= tlb_ptr_d;
      end
      if (fault) begin
        mapped_q[page_q] <= 1'b1;
        next_free_q      <= next_free_q + 1'b1;
      end
    end
  end

  // TLB payload insert
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && miss) begin
      tlb_page_q[tlb_ptr_q]  <= page_q;
      tlb_frame_q[tlb_ptr_q] <= frame;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      pa_q        <= pa_ext[AddrWidth-1:0];
      res_hit_q   <= hit_q;
      res_fault_q <= fault;
    end
  end

  assign phys_addr_o  = pa_q;
  assign tlb_hit_o    = res_hit_q;
  assign page_fault_o = res_fault_q;

endmodule

@@ hw/rtl/tlb_page_table_translator.sv @@
// Flow: a request is taken in S_IDLE, where the TLB is searched and the page table read;
// in S_COMMIT the result is registered and then shows on the response port.
// One request at a time: the page table memory read is followed by the commit,
// which writes it back on a fault; a stalled response holds the commit cycle.
// Reset: asynchronous, clears TLB valid bits, FIFO pointer, page mapped flags and the
// free frame counter; no clearing pass, the block takes requests right after reset.
module tlb_page_table_translator (
  input  logic      clk_i,
  input  logic      rst_ni,
  tlb_va_if.sink    req_i,
  tlb_pa_if.source  rsp_o
);

  tlb_pkg::tlb_cmd_t cmd;

  // Sequencer
  tlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // TLB, page table and result register
  tlb_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .virtual_address_i (req_i.virtual_address),
    .phys_addr_o       (rsp_o.phys_addr),
    .tlb_hit_o         (rsp_o.tlb_hit),
    .page_fault_o      (rsp_o.page_fault)
  );

endmodule

@@ hw/rtl/tlb_checker.sv @@
module tlb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [tlb_pkg::AddrWidth-1:0] phys_addr_i,
  input logic                          tlb_hit_i,
  input logic                          page_fault_i
);

  // A fault only happens on a TLB miss
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(tlb_hit_i && page_fault_i))
    else $error("tlb: hit and fault flagged together");

  // One request in flight: no request taken in the cycle after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("tlb: request taken while previous one still in flight");

  // No response during reset
  assert property (@(posedge clk_i) !rst_ni |-> !rsp_valid_i)
    else $error("tlb: response valid during reset");

  // Stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(phys_addr_i) && $stable(tlb_hit_i)
       && $stable(page_fault_i)))
    else $error("tlb: stalled response changed");

endmodule

bind tlb_page_table_translator tlb_checker u_tlb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .phys_addr_i  (rsp_o.phys_addr),
  .tlb_hit_i    (rsp_o.tlb_hit),
  .page_fault_i (rsp_o.page_fault)
);
